// ===== src/atte_pkg.sv =====
// shared types, constants and helpers for the ansi text terminal engine
`timescale 1ns / 1ps
package atte_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_CSI_SLOTS   = 8;
    localparam int DEF_TAB_STOP    = 8;

    localparam int VALUE_W      = 20;
    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 20'd100000;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_HIGH  = 8'h80;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    localparam logic [3:0] FG_DEFAULT = 4'd7;
    localparam logic [3:0] BG_DEFAULT = 4'd0;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] PM_GROUND = 2'd0;
    localparam logic [1:0] PM_ESC    = 2'd1;
    localparam logic [1:0] PM_CSI    = 2'd2;

    localparam logic [0:0] REG_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ROWS    = 1'b1;

    // sweep kinds driven by the controller
    typedef enum logic [2:0] {
        SW_NONE  = 3'd0,
        SW_BLANK = 3'd1,   // write blank cells over a linear range
        SW_COPY  = 3'd2    // scroll: copy row r to r-1 over a range
    } sweep_kind_t;

    // command from controller to datapath
    typedef struct packed {
        logic       mem_we;
        logic       mem_re;
        logic [6:0] row;
        logic [7:0] col;
        logic [15:0] wdata;
        logic       wr_from_rd;  // write the registered read data
    } mem_cmd_t;

    function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                              input logic [3:0] bg);
        make_cell = {bg, fg, ch};
    endfunction

endpackage

// ===== src/atte_cell_mem.sv =====
// cell store: one address shared by the write path and the registered read path
`timescale 1ns / 1ps
module atte_cell_mem
#(
    parameter int MAX_COLUMNS = atte_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atte_pkg::DEF_MAX_ROWS
)
(
    input  logic                    clk,
    input  atte_pkg::mem_cmd_t      cmd,
    output logic [15:0]             rdata
);
    import atte_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = CW + RW;

    logic [15:0] mem_reg [0:(1<<AW)-1];
    logic [15:0] rdata_reg;
    logic [AW-1:0] addr;
    logic [15:0] wval;

    assign addr  = {cmd.row[RW-1:0], cmd.col[CW-1:0]};
    assign wval  = cmd.wr_from_rd ? rdata_reg : cmd.wdata;
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem_reg[addr] <= wval;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

endmodule

// ===== src/atte_ctrl.sv =====
// controller: parser, cursor, colors, sweeps over the cell store
`timescale 1ns / 1ps
module atte_ctrl
#(
    parameter int MAX_COLUMNS = atte_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atte_pkg::DEF_MAX_ROWS,
    parameter int CSI_SLOTS   = atte_pkg::DEF_CSI_SLOTS,
    parameter int TAB_STOP    = atte_pkg::DEF_TAB_STOP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [7:0]         data_byte,
    input  logic [5:0]         read_row,
    input  logic [6:0]         read_column,
    input  logic [7:0]         cols,      // clamped
    input  logic [6:0]         rows,      // clamped
    input  logic               cfg_we,
    output atte_pkg::mem_cmd_t cmd,
    input  logic [15:0]        rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [37:0]        res_data
);
    import atte_pkg::*;

    localparam int SW = $clog2(CSI_SLOTS);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_BLANK = 7'b0000100,
        S_CRD   = 7'b0001000,
        S_CWR   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] crow_reg, crow_next;
    logic [7:0] ccol_reg, ccol_next;
    logic [3:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [1:0] pm_reg, pm_next;
    logic [VALUE_W-1:0] vals_reg [0:CSI_SLOTS-1];
    logic [VALUE_W-1:0] vals_next [0:CSI_SLOTS-1];
    logic [4:0] vcnt_reg, vcnt_next;
    // sweep position and limits
    logic [6:0] sr_reg, sr_next, er_reg, er_next;
    logic [7:0] sc_reg, sc_next, ec_reg, ec_next;
    logic [7:0] lc_reg, lc_next;      // line end column for multi-row blank
    logic        tab_reg, tab_next;    // tab pending after blank
    logic        rd_reg, rd_next;      // item was read
    logic        inb_reg, inb_next;    // read inside grid
    logic [37:0] res_reg, res_next;
    logic        rv_reg, rv_next;

    // scratch
    logic [VALUE_W-1:0] a0, a1, v, a0z;
    logic [20:0] sum;
    logic [4:0]  vi;
    logic        bump;
    logic [7:0]  pc_ch;
    logic        do_place;

    // column sits on a tab stop
    function automatic logic at_stop(input logic [7:0] c);
        at_stop = 1'b0;
        for (int k = 0; k < 256; k += TAB_STOP)
            if (c == 8'(k)) at_stop = 1'b1;
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !rv_reg && !cfg_we;
    assign res_valid = rv_reg;
    assign res_data  = res_reg;
    assign a0z = vals_reg[0];
    assign a0 = (vcnt_reg > 5'd0 && a0z != '0) ? a0z : VALUE_W'(1);
    assign a1 = (vcnt_reg > 5'd1 && vals_reg[1] != '0) ? vals_reg[1] : VALUE_W'(1);

    always_comb
    begin
        state_next = state_reg;
        crow_next = crow_reg; ccol_next = ccol_reg;
        fg_next = fg_reg; bg_next = bg_reg; pm_next = pm_reg;
        for (int i = 0; i < CSI_SLOTS; i++) vals_next[i] = vals_reg[i];
        vcnt_next = vcnt_reg;
        sr_next = sr_reg; er_next = er_reg; sc_next = sc_reg; ec_next = ec_reg;
        lc_next = lc_reg;
        tab_next = tab_reg; rd_next = rd_reg; inb_next = inb_reg;
        res_next = res_reg; rv_next = rv_reg;
        cmd = '0;
        sum = '0; vi = '0; v = '0; bump = 1'b0;
        pc_ch = CH_SPACE; do_place = 1'b0;

        if (rv_reg && res_ready) rv_next = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                cmd.mem_we = 1'b1;
                cmd.row = sr_reg; cmd.col = sc_reg;
                cmd.wdata = make_cell(CH_SPACE, FG_DEFAULT, BG_DEFAULT);
                if (sc_reg == 8'(MAX_COLUMNS - 1))
                begin
                    sc_next = '0;
                    if (sr_reg == 7'(MAX_ROWS - 1)) state_next = S_IDLE;
                    else sr_next = sr_reg + 7'd1;
                end
                else sc_next = sc_reg + 8'd1;
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    if (crow_reg >= rows) crow_next = rows - 7'd1;
                    if (ccol_reg >= cols) ccol_next = cols - 8'd1;
                end
                else if (in_valid && in_ready)
                begin
                    rd_next = 1'b0; tab_next = 1'b0;
                    state_next = S_OUT;
                    if (opcode == OP_READ)
                    begin
                        rd_next = 1'b1;
                        inb_next = ({1'b0, read_row} < rows) && ({1'b0, read_column} < cols);
                        cmd.mem_re = 1'b1;
                        cmd.row = {1'b0, read_row};
                        cmd.col = {1'b0, read_column};
                        state_next = S_READ;
                    end
                    else if (pm_reg == PM_ESC)
                    begin
                        pm_next = PM_GROUND;
                        if (data_byte == CH_LBRK)
                        begin
                            for (int i = 0; i < CSI_SLOTS; i++) vals_next[i] = '0;
                            vcnt_next = 5'd1; pm_next = PM_CSI;
                        end
                        else if (data_byte == "c")
                        begin
                            fg_next = FG_DEFAULT; bg_next = BG_DEFAULT;
                            crow_next = '0; ccol_next = '0;
                            sr_next = '0; sc_next = '0; er_next = rows - 7'd1;
                            ec_next = cols - 8'd1; lc_next = cols - 8'd1;
                            state_next = S_BLANK;
                        end
                    end
                    else if (pm_reg == PM_CSI)
                    begin
                        if (data_byte >= "0" && data_byte <= "9")
                        begin
                            vi = (vcnt_reg == 5'd0) ? 5'd0 : vcnt_reg - 5'd1;
                            if (vcnt_reg == 5'd0) vcnt_next = 5'd1;
                            v = vals_reg[vi[SW-1:0]];
                            vals_next[vi[SW-1:0]] = (v > VALUE_LIMIT) ? VALUE_LIMIT :
                                VALUE_W'(v * 4'd10) + VALUE_W'(data_byte - "0");
                        end
                        else if (data_byte == CH_SEMI && vcnt_reg < 5'(CSI_SLOTS))
                            vcnt_next = vcnt_reg + 5'd1;
                        else if (data_byte != CH_QUEST)
                        begin
                            pm_next = PM_GROUND;
                            case (data_byte)
                                "A": crow_next = (a0 > VALUE_W'(crow_reg)) ? '0 :
                                                 crow_reg - a0[6:0];
                                "B":
                                begin
                                    sum = 21'(crow_reg) + 21'(a0);
                                    crow_next = (sum >= 21'(rows)) ? rows - 7'd1 : sum[6:0];
                                end
                                "C":
                                begin
                                    sum = 21'(ccol_reg) + 21'(a0);
                                    ccol_next = (sum >= 21'(cols)) ? cols - 8'd1 : sum[7:0];
                                end
                                "D": ccol_next = (a0 > VALUE_W'(ccol_reg)) ? '0 :
                                                 ccol_reg - a0[7:0];
                                "H", "f":
                                begin
                                    crow_next = (a0 > VALUE_W'(rows)) ? rows - 7'd1 :
                                                a0[6:0] - 7'd1;
                                    ccol_next = (a1 > VALUE_W'(cols)) ? cols - 8'd1 :
                                                a1[7:0] - 8'd1;
                                end
                                "J":
                                begin
                                    er_next = rows - 7'd1; ec_next = cols - 8'd1;
                                    lc_next = cols - 8'd1;
                                    state_next = S_BLANK;
                                    if (vcnt_reg > 5'd0 && a0z >= VALUE_W'(2))
                                    begin
                                        sr_next = '0; sc_next = '0;
                                        crow_next = '0; ccol_next = '0;
                                    end
                                    else
                                    begin
                                        sr_next = crow_reg; sc_next = ccol_reg;
                                        if (ccol_reg >= cols)
                                        begin
                                            // nothing on this row
                                            sc_next = '0; sr_next = crow_reg + 7'd1;
                                        end
                                        if (crow_reg >= rows - 7'd1 && ccol_reg >= cols)
                                            state_next = S_OUT;
                                    end
                                end
                                "K":
                                begin
                                    sr_next = crow_reg; er_next = crow_reg;
                                    state_next = S_BLANK;
                                    if (vcnt_reg == 5'd0 || a0z == '0)
                                    begin
                                        sc_next = ccol_reg; ec_next = cols - 8'd1;
                                        if (ccol_reg >= cols) state_next = S_OUT;
                                    end
                                    else if (a0z == VALUE_W'(1))
                                    begin
                                        sc_next = '0; ec_next = ccol_reg;
                                    end
                                    else
                                    begin
                                        sc_next = '0; ec_next = cols - 8'd1;
                                    end
                                    lc_next = ec_next;
                                end
                                "m":
                                begin
                                    for (int i = 0; i < CSI_SLOTS; i++)
                                    begin
                                        if (5'(i) < vcnt_reg)
                                        begin
                                            v = vals_reg[i];
                                            if (v == '0)
                                            begin
                                                fg_next = FG_DEFAULT; bg_next = BG_DEFAULT;
                                            end
                                            else if (v >= 30 && v <= 37) fg_next = 4'(v - 30);
                                            else if (v >= 40 && v <= 47) bg_next = 4'(v - 40);
                                            else if (v >= 90 && v <= 97) fg_next = 4'(v - 82);
                                            else if (v >= 100 && v <= 107) bg_next = 4'(v - 92);
                                            else if (v == 1) fg_next = fg_next | 4'd8;
                                            else if (v == 39) fg_next = FG_DEFAULT;
                                            else if (v == 49) bg_next = BG_DEFAULT;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    else
                    begin
                        if (data_byte == CH_ESC) pm_next = PM_ESC;
                        else if (data_byte == CH_CR) ccol_next = '0;
                        else if (data_byte == CH_LF) bump = 1'b1;
                        else if (data_byte == CH_BS)
                        begin
                            if (ccol_reg != '0) ccol_next = ccol_reg - 8'd1;
                        end
                        else if (data_byte == CH_TAB)
                        begin
                            do_place = 1'b1; pc_ch = CH_SPACE; tab_next = 1'b1;
                        end
                        else if (data_byte >= CH_SPACE && data_byte < CH_DEL)
                        begin
                            do_place = 1'b1; pc_ch = data_byte;
                        end
                        else if (data_byte >= CH_HIGH)
                        begin
                            do_place = 1'b1; pc_ch = CH_QUEST;
                        end
                    end
                end
            end
            S_BLANK:
            begin
                // tab continuation uses this state with sr/sc on cursor
                cmd.mem_we = 1'b1;
                cmd.row = sr_reg; cmd.col = sc_reg;
                cmd.wdata = make_cell(CH_SPACE, fg_reg, bg_reg);
                if (tab_reg)
                begin
                    do_place = 1'b0;
                    if (ccol_reg + 8'd1 >= cols)
                    begin
                        tab_next = 1'b0; bump = 1'b1;
                    end
                    else
                    begin
                        ccol_next = ccol_reg + 8'd1;
                        sc_next = ccol_reg + 8'd1;
                        if (at_stop(ccol_next))
                        begin
                            tab_next = 1'b0; state_next = S_OUT;
                        end
                    end
                end
                else if (sc_reg >= ec_reg)
                begin
                    if (sr_reg >= er_reg) state_next = S_OUT;
                    else
                    begin
                        sr_next = sr_reg + 7'd1; sc_next = '0; ec_next = lc_reg;
                    end
                end
                else sc_next = sc_reg + 8'd1;
            end
            S_CRD:
            begin
                cmd.mem_re = 1'b1;
                cmd.row = sr_reg; cmd.col = sc_reg;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.mem_we = 1'b1; cmd.wr_from_rd = 1'b1;
                cmd.row = sr_reg - 7'd1; cmd.col = sc_reg;
                state_next = S_CRD;
                if (sc_reg == cols - 8'd1)
                begin
                    sc_next = '0;
                    if (sr_reg == rows - 7'd1)
                    begin
                        // blank the last row
                        sr_next = rows - 7'd1; er_next = rows - 7'd1;
                        ec_next = cols - 8'd1; lc_next = cols - 8'd1;
                        state_next = S_BLANK;
                    end
                    else sr_next = sr_reg + 7'd1;
                end
                else sc_next = sc_reg + 8'd1;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg)
                begin
                    rv_next = 1'b1;
                    res_next = {1'b0,
                                inb_reg && rd_reg ? rdata[15:12] : 4'd0,
                                inb_reg && rd_reg ? rdata[11:8] : 4'd0,
                                inb_reg && rd_reg ? rdata[7:0] : 8'd0,
                                bg_reg, fg_reg, ccol_reg[6:0], crow_reg[5:0]};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_place)
        begin
            cmd.mem_we = 1'b1;
            cmd.row = crow_reg; cmd.col = ccol_reg;
            cmd.wdata = make_cell(pc_ch, fg_reg, bg_reg);
            if (ccol_reg + 8'd1 >= cols) bump = 1'b1;
            else
            begin
                ccol_next = ccol_reg + 8'd1;
                if (tab_next && !at_stop(ccol_next))
                begin
                    sr_next = crow_reg; sc_next = ccol_next; state_next = S_BLANK;
                end
                else tab_next = 1'b0;
            end
        end

        if (bump)
        begin
            // new line, scroll when past the last row
            ccol_next = '0;
            if (crow_reg + 7'd1 < rows)
            begin
                crow_next = crow_reg + 7'd1;
                state_next = S_OUT;
            end
            else
            begin
                crow_next = rows - 7'd1;
                if (rows == 7'd1)
                begin
                    sr_next = '0; sc_next = '0; er_next = '0;
                    ec_next = cols - 8'd1; lc_next = cols - 8'd1;
                    state_next = S_BLANK;
                end
                else
                begin
                    sr_next = 7'd1; sc_next = '0; state_next = S_CRD;
                end
            end
            // a tab that wraps lands at column 0, which is a stop
            tab_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            crow_reg <= '0; ccol_reg <= '0;
            fg_reg <= FG_DEFAULT; bg_reg <= BG_DEFAULT;
            pm_reg <= PM_GROUND; vcnt_reg <= '0;
            for (int i = 0; i < CSI_SLOTS; i++) vals_reg[i] <= '0;
            sr_reg <= '0; sc_reg <= '0; er_reg <= '0; ec_reg <= '0; lc_reg <= '0;
            tab_reg <= 1'b0; rd_reg <= 1'b0; inb_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            crow_reg <= crow_next; ccol_reg <= ccol_next;
            fg_reg <= fg_next; bg_reg <= bg_next;
            pm_reg <= pm_next; vcnt_reg <= vcnt_next;
            for (int i = 0; i < CSI_SLOTS; i++) vals_reg[i] <= vals_next[i];
            sr_reg <= sr_next; sc_reg <= sc_next; er_reg <= er_next; ec_reg <= ec_next;
            lc_reg <= lc_next;
            tab_reg <= tab_next; rd_reg <= rd_next; inb_reg <= inb_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== src/atte_cfg.sv =====
// apb configuration registers with clamped grid size
`timescale 1ns / 1ps
module atte_cfg
#(
    parameter int MAX_COLUMNS = atte_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atte_pkg::DEF_MAX_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        we,
    output logic [7:0]  cols,
    output logic [6:0]  rows
);
    import atte_pkg::*;

    logic [7:0] col_reg;
    logic [6:0] row_reg;
    logic       wr_reg;

    assign we = wr_reg;
    assign cols = (col_reg == '0) ? 8'd1 :
                  (9'(col_reg) > 9'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : col_reg;
    assign rows = (row_reg == '0) ? 7'd1 :
                  (8'(row_reg) > 8'(MAX_ROWS)) ? 7'(MAX_ROWS) : row_reg;
    assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, row_reg} : {24'd0, col_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 8'd80;
            row_reg <= 7'd25;
            wr_reg <= 1'b0;
        end
        else
        begin
            wr_reg <= 1'b0;
            if (psel && penable && pwrite && paddr[1:0] == 2'd0)
            begin
                if (paddr[2] == REG_COLUMNS) col_reg <= pwdata[7:0];
                else row_reg <= pwdata[6:0];
                wr_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== src/ansi_text_terminal_engine.sv =====
// top level: ansi text terminal engine
// result: registered after S_OUT for a byte, after S_READ and S_OUT for a read
// sweeps: scroll shifts rows up, blanks the last row; erase and tab go cell by cell
// flow: one transaction at a time, the next only after the result is accepted
// reset: async, active low; then a clearing pass writes every cell of the store and
// takes no items while it runs
`timescale 1ns / 1ps
module ansi_text_terminal_engine
#(
    parameter int MAX_COLUMNS = atte_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atte_pkg::DEF_MAX_ROWS,
    parameter int CSI_SLOTS   = atte_pkg::DEF_CSI_SLOTS,
    parameter int TAB_STOP    = atte_pkg::DEF_TAB_STOP
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: opcode, data_byte, read_row, read_column, zero pad
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cursor_row, cursor_column, current_foreground, current_background,
    // cell_character, cell_foreground, cell_background, zero pad
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import atte_pkg::*;

    mem_cmd_t    cmd;
    logic [15:0] rdata;
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic        cfg_we;
    logic [37:0] res;

    assign pready = 1'b1;
    assign m_axis_tdata = {2'b00, res};

    atte_cfg #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_cfg
    (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .we(cfg_we),
        .cols(cols), .rows(rows)
    );

    atte_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS),
                .CSI_SLOTS(CSI_SLOTS), .TAB_STOP(TAB_STOP)) u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .opcode(s_axis_tdata[0]), .data_byte(s_axis_tdata[8:1]),
        .read_row(s_axis_tdata[14:9]), .read_column(s_axis_tdata[21:15]),
        .cols(cols), .rows(rows), .cfg_we(cfg_we),
        .cmd(cmd), .rdata(rdata),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
    );

    atte_cell_mem #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_mem
    (
        .clk(clk), .cmd(cmd), .rdata(rdata)
    );

endmodule

// ===== src/atte_checker.sv =====
// port-level checks for the ansi text terminal engine
`timescale 1ns / 1ps
module atte_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken before result");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with a result pending");
    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");
endmodule

bind ansi_text_terminal_engine atte_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

// ===== bench/tb_top.sv =====
// testbench for the ansi text terminal engine: directed table plus random byte streams
`timescale 1ns / 1ps
module tb_top;
    import atte_pkg::*;

    localparam int COLS_MAX  = DEF_MAX_COLUMNS;
    localparam int ROWS_MAX  = DEF_MAX_ROWS;
    localparam int SLOTS     = DEF_CSI_SLOTS;
    localparam int TAB_EVERY = DEF_TAB_STOP;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic [5:0] cur_row;
        logic [6:0] cur_col;
        logic [3:0] cur_fg;
        logic [3:0] cur_bg;
        logic [7:0] cell_ch;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
    } term_view_t;

    // one directed row: check_view set means the expected result is typed in
    typedef struct {
        logic       op;
        logic [7:0] byte_in;
        logic [5:0] row;
        logic [6:0] col;
        bit         check_view;
        term_view_t view;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ansi_text_terminal_engine u_top (.*);

    // shadow terminal state
    logic [15:0] grid_cells [ROWS_MAX*COLS_MAX];
    int unsigned col_reg;
    int unsigned row_reg;
    int unsigned cur_r;
    int unsigned cur_c;
    logic [3:0]  fg_now;
    logic [3:0]  bg_now;
    logic [1:0]  parse_state;
    int unsigned csi_vals [SLOTS];
    int unsigned csi_count;

    term_view_t  expected_views [$];
    int          error_count;
    longint      cycle_count;
    int          views_checked;
    bit          idle_on;

    function automatic int unsigned used_cols();
        if (col_reg == 0) return 1;
        if (col_reg > COLS_MAX) return COLS_MAX;
        return col_reg;
    endfunction

    function automatic int unsigned used_rows();
        if (row_reg == 0) return 1;
        if (row_reg > ROWS_MAX) return ROWS_MAX;
        return row_reg;
    endfunction

    function automatic void blank_at(int unsigned r, int unsigned c);
        if (r < ROWS_MAX && c < COLS_MAX)
            grid_cells[r*COLS_MAX + c] = {bg_now, fg_now, CH_SPACE};
    endfunction

    function automatic void wipe_grid();
        for (int unsigned r = 0; r < used_rows(); r++)
            for (int unsigned c = 0; c < used_cols(); c++)
                blank_at(r, c);
        cur_r = 0;
        cur_c = 0;
    endfunction

    function automatic void next_line();
        int unsigned rows;
        int unsigned cols;
        rows = used_rows();
        cols = used_cols();
        cur_c = 0;
        cur_r++;
        if (cur_r < rows) return;
        for (int unsigned r = 1; r < rows; r++)
            for (int unsigned c = 0; c < cols; c++)
                grid_cells[(r-1)*COLS_MAX + c] = grid_cells[r*COLS_MAX + c];
        cur_r = rows - 1;
        for (int unsigned c = 0; c < cols; c++)
            blank_at(cur_r, c);
    endfunction

    function automatic void put_char(logic [7:0] ch);
        if (cur_r < ROWS_MAX && cur_c < COLS_MAX)
            grid_cells[cur_r*COLS_MAX + cur_c] = {bg_now, fg_now, ch};
        cur_c++;
        if (cur_c >= used_cols()) next_line();
    endfunction

    function automatic int unsigned csi_param(int unsigned i, int unsigned dflt);
        if (i < csi_count && i < SLOTS && csi_vals[i] != 0) return csi_vals[i];
        return dflt;
    endfunction

    function automatic void finish_csi(logic [7:0] fin);
        int unsigned rows;
        int unsigned cols;
        int unsigned n;
        int unsigned p;
        int unsigned q;
        int unsigned mode;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        rows = used_rows();
        cols = used_cols();
        n = csi_param(0, 1);
        case (fin)
            "A": cur_r = (n > cur_r) ? 0 : cur_r - n;
            "B": cur_r = (cur_r + n >= rows) ? rows - 1 : cur_r + n;
            "C": cur_c = (cur_c + n >= cols) ? cols - 1 : cur_c + n;
            "D": cur_c = (n > cur_c) ? 0 : cur_c - n;
            "H", "f":
            begin
                p = csi_param(0, 1);
                q = csi_param(1, 1);
                cur_r = (p > rows) ? rows - 1 : p - 1;
                cur_c = (q > cols) ? cols - 1 : q - 1;
            end
            "J":
            begin
                if (csi_param(0, 0) >= 2)
                    wipe_grid();
                else
                begin
                    for (int unsigned c = cur_c; c < cols; c++) blank_at(cur_r, c);
                    for (int unsigned r = cur_r + 1; r < rows; r++)
                        for (int unsigned c = 0; c < cols; c++) blank_at(r, c);
                end
            end
            "K":
            begin
                mode = csi_param(0, 0);
                lo = (mode == 0) ? cur_c : 0;
                hi = (mode == 1) ? cur_c + 1 : cols;
                for (int unsigned c = lo; c < hi; c++) blank_at(cur_r, c);
            end
            "m":
            begin
                for (int unsigned i = 0; i < csi_count && i < SLOTS; i++)
                begin
                    v = csi_vals[i];
                    if (v == 0) begin fg_now = FG_DEFAULT; bg_now = BG_DEFAULT; end
                    else if (v >= 30 && v <= 37) fg_now = 4'(v - 30);
                    else if (v >= 40 && v <= 47) bg_now = 4'(v - 40);
                    else if (v >= 90 && v <= 97) fg_now = 4'(v - 90 + 8);
                    else if (v >= 100 && v <= 107) bg_now = 4'(v - 100 + 8);
                    else if (v == 1) fg_now = fg_now | 4'd8;
                    else if (v == 39) fg_now = FG_DEFAULT;
                    else if (v == 49) bg_now = BG_DEFAULT;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        int unsigned k;
        if (parse_state == PM_ESC)
        begin
            if (b == CH_LBRK)
            begin
                foreach (csi_vals[i]) csi_vals[i] = 0;
                csi_count = 1;
                parse_state = PM_CSI;
            end
            else
            begin
                parse_state = PM_GROUND;
                if (b == "c")
                begin
                    fg_now = FG_DEFAULT;
                    bg_now = BG_DEFAULT;
                    wipe_grid();
                end
            end
            return;
        end
        if (parse_state == PM_CSI)
        begin
            if (b >= "0" && b <= "9")
            begin
                if (csi_count == 0) csi_count = 1;
                k = (csi_count - 1) % SLOTS;
                csi_vals[k] = (csi_vals[k] > VALUE_LIMIT) ? VALUE_LIMIT
                            : csi_vals[k] * 10 + (b - "0");
            end
            else if (b == CH_SEMI && csi_count < SLOTS)
                csi_count++;
            else if (b != CH_QUEST)
            begin
                finish_csi(b);
                parse_state = PM_GROUND;
            end
            return;
        end
        parse_state = PM_GROUND;
        if (b == CH_ESC) parse_state = PM_ESC;
        else if (b == CH_CR) cur_c = 0;
        else if (b == CH_LF) next_line();
        else if (b == CH_BS) begin if (cur_c != 0) cur_c--; end
        else if (b == CH_TAB)
        begin
            do put_char(CH_SPACE); while (cur_c % TAB_EVERY != 0);
        end
        else if (b >= CH_SPACE && b < CH_DEL) put_char(b);
        else if (b >= CH_HIGH) put_char(CH_QUEST);
    endfunction

    // advance the shadow terminal by one transaction and return its view
    function automatic term_view_t terminal_step(logic op, logic [7:0] b,
                                                 logic [5:0] rr, logic [6:0] rc);
        term_view_t v;
        logic [15:0] grid_word;
        v = '0;
        if (op == OP_FEED)
            feed_byte(b);
        else if (rr < used_rows() && rc < used_cols())
        begin
            grid_word = grid_cells[rr*COLS_MAX + rc];
            v.cell_ch = grid_word[7:0];
            v.cell_fg = grid_word[11:8];
            v.cell_bg = grid_word[15:12];
        end
        v.cur_row = cur_r[5:0];
        v.cur_col = cur_c[6:0];
        v.cur_fg  = fg_now;
        v.cur_bg  = bg_now;
        return v;
    endfunction

    function automatic void terminal_reset();
        foreach (grid_cells[i]) grid_cells[i] = {BG_DEFAULT, FG_DEFAULT, CH_SPACE};
        col_reg = 80;
        row_reg = 25;
        cur_r = 0;
        cur_c = 0;
        fg_now = FG_DEFAULT;
        bg_now = BG_DEFAULT;
        parse_state = PM_GROUND;
        foreach (csi_vals[i]) csi_vals[i] = 0;
        csi_count = 0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side: random stall bursts, compare against oldest expectation
    initial
    begin
        term_view_t got;
        term_view_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.cur_row = m_axis_tdata[5:0];
                got.cur_col = m_axis_tdata[12:6];
                got.cur_fg  = m_axis_tdata[16:13];
                got.cur_bg  = m_axis_tdata[20:17];
                got.cell_ch = m_axis_tdata[28:21];
                got.cell_fg = m_axis_tdata[32:29];
                got.cell_bg = m_axis_tdata[36:33];
                if (expected_views.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    error_count++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    views_checked++;
                    if (got.cur_row != want.cur_row)
                        begin $error("cursor_row exp %0d got %0d", want.cur_row, got.cur_row); error_count++; end
                    if (got.cur_col != want.cur_col)
                        begin $error("cursor_column exp %0d got %0d", want.cur_col, got.cur_col); error_count++; end
                    if (got.cur_fg != want.cur_fg)
                        begin $error("current_foreground exp %0d got %0d", want.cur_fg, got.cur_fg); error_count++; end
                    if (got.cur_bg != want.cur_bg)
                        begin $error("current_background exp %0d got %0d", want.cur_bg, got.cur_bg); error_count++; end
                    if (got.cell_ch != want.cell_ch)
                        begin $error("cell_character exp %h got %h", want.cell_ch, got.cell_ch); error_count++; end
                    if (got.cell_fg != want.cell_fg)
                        begin $error("cell_foreground exp %0d got %0d", want.cell_fg, got.cell_fg); error_count++; end
                    if (got.cell_bg != want.cell_bg)
                        begin $error("cell_background exp %0d got %0d", want.cell_bg, got.cell_bg); error_count++; end
                end
            end
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(logic op, logic [7:0] b, logic [5:0] rr, logic [6:0] rc,
                             bit typed, term_view_t typed_view);
        term_view_t v;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tdata  <= {2'b00, rc, rr, b, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        v = terminal_step(op, b, rr, rc);
        if (typed && v != typed_view)
        begin
            $error("typed row disagrees with prediction: exp %h pred %h", typed_view, v);
            error_count++;
        end
        expected_views.push_back(typed ? typed_view : v);
    endtask

    task automatic feed(logic [7:0] b);
        send_item(OP_FEED, b, 6'($urandom), 7'($urandom), 1'b0, '0);
    endtask

    task automatic read_cell(logic [5:0] rr, logic [6:0] rc);
        send_item(OP_READ, 8'($urandom), rr, rc, 1'b0, '0);
    endtask

    task automatic feed_text(string s);
        for (int i = 0; i < s.len(); i++) feed(s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
        // a scroll or full erase may still be walking the grid
        repeat (2*ROWS_MAX*COLS_MAX + 50) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0) col_reg = data & 8'hff;
        else row_reg = data & 7'h7f;
        if (cur_r >= used_rows()) cur_r = used_rows() - 1;
        if (cur_c >= used_cols()) cur_c = used_cols() - 1;
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows);
        drain();
        apb_write({REG_COLUMNS, 2'b00}, cols);
        apb_write({REG_ROWS, 2'b00}, rows);
    endtask

    // random stream of text, raw bytes, cell reads and mostly well-formed escape sequences
    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 19);
            if (k < 5) feed(8'($urandom_range(8'h20, 8'h7e)));
            else if (k < 6) feed(8'($urandom));
            else if (k < 7) feed(8'($urandom_range(0, 31)));
            else if (k < 11)
                read_cell(6'($urandom_range(0, used_rows())),
                          7'($urandom_range(0, used_cols())));
            else if (k < 12) read_cell(6'($urandom), 7'($urandom));
            else
            begin
                feed(CH_ESC);
                if ($urandom_range(0, 9) == 0)
                    feed($urandom_range(0, 9) < 3 ? "c" : 8'($urandom));
                else
                begin
                    feed(CH_LBRK);
                    for (int p = $urandom_range(0, 3); p > 0; p--)
                    begin
                        case ($urandom_range(0, 3))
                            0: feed_text($sformatf("%0d", $urandom_range(0, 9)));
                            1: feed_text($sformatf("%0d", $urandom_range(0, 110)));
                            2: feed_text($sformatf("%0d", $urandom_range(0, 70)));
                            default: feed("?");
                        endcase
                        if (p > 1) feed(CH_SEMI);
                    end
                    case ($urandom_range(0, 11))
                        0: feed("A");
                        1: feed("B");
                        2: feed("C");
                        3: feed("D");
                        4: feed("H");
                        5: feed("f");
                        6: feed($urandom_range(0, 7) == 0 ? "J" : "K");
                        7: feed("K");
                        8, 9: feed("m");
                        default: feed(8'($urandom));
                    endcase
                end
            end
        end
    endtask

    stim_row_t directed_rows [$];

    function automatic stim_row_t row_of(logic op, logic [7:0] b, logic [5:0] rr,
                                         logic [6:0] rc, bit typed, term_view_t v);
        stim_row_t s;
        s.op = op; s.byte_in = b; s.row = rr; s.col = rc; s.check_view = typed; s.view = v;
        return s;
    endfunction

    initial
    begin
        error_count   = 0;
        views_checked = 0;
        idle_on       = 1'b1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        terminal_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // view fields: row, col, fg, bg, char, cell fg, cell bg
        directed_rows.push_back(row_of(OP_READ, 0, 0, 0, 1, '{0, 0, 7, 0, 8'h20, 7, 0}));
        directed_rows.push_back(row_of(OP_READ, 0, 63, 127, 1, '{0, 0, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_READ, 0, 24, 79, 1, '{0, 0, 7, 0, 8'h20, 7, 0}));
        directed_rows.push_back(row_of(OP_FEED, 8'h41, 0, 0, 1, '{0, 1, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, 8'hff, 0, 0, 1, '{0, 2, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_READ, 0, 0, 1, 1, '{0, 2, 7, 0, 8'h3f, 7, 0}));
        directed_rows.push_back(row_of(OP_FEED, 8'h00, 0, 0, 1, '{0, 2, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, 8'h7f, 0, 0, 1, '{0, 2, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, CH_BS, 0, 0, 1, '{0, 1, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, CH_TAB, 0, 0, 1, '{0, 8, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, CH_LF, 0, 0, 1, '{1, 0, 7, 0, 0, 0, 0}));
        directed_rows.push_back(row_of(OP_FEED, "x", 0, 0, 0, '0));
        directed_rows.push_back(row_of(OP_FEED, CH_CR, 0, 0, 0, '0));
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].byte_in, directed_rows[i].row,
                      directed_rows[i].col, directed_rows[i].check_view, directed_rows[i].view);
        // escape handling: colors, moves, erase, overflow, separators, esc c
        feed_text("\033[1;31;42m*\033[90;100mQ\033[39;49m\033[0m\033[5;9H");
        feed_text("\033[A\033[B\033[C\033[D\033[999999999;999f\033[1;2;3;4;5;6;7;8;9m");
        feed_text("\033[?2J\033[3;4H\033[1K\033[2K\033[K\033[J\033\033zx\033c");
        read_cell(0, 0);

        // grid extremes, including out of range register values
        set_grid(1, 1);
        feed_text("ab\n\t");
        read_cell(0, 0);
        set_grid(0, 0);
        feed_text("q");
        read_cell(0, 0);
        set_grid(255, 127);
        random_phase(15);
        set_grid(128, 64);
        feed_text("\033[64;128H\n\033[2J");
        read_cell(63, 127);
        set_grid(8, 4);
        random_phase(40);
        set_grid(13, 3);
        random_phase(30);
        idle_on = 1'b0;
        set_grid(20, 6);
        random_phase(30);
        drain();

        $display("covered directed controls, escape sequences and grid sizes 1x1 to 128x64,");
        $display("%0d results checked against the terminal predictor", views_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
